// File: hw/rtl/fmfc_pkg.sv
// ----------------------------------------------------------------------------
// fmfc_pkg: shared types and constants for the flow metered fill controller
// Commands, run modes, sequencer states, register indexes, duty conversion.
// ----------------------------------------------------------------------------
package fmfc_pkg;

  // rate update interval and PWM full scale
  localparam int unsigned TICKS_PER_RATE = 5;
  localparam int unsigned PWM_TOP        = 255;
  localparam int unsigned PCT_FULL       = 100;

  // serial divider: dividend width and step counter width
  localparam int unsigned DIV_BITS = 30;
  localparam int unsigned CNT_W    = $clog2(DIV_BITS + 1);

  // reset values of the configuration registers
  localparam logic [7:0]  CAL_RESET    = 8'd75;
  localparam logic [15:0] OFFSET_RESET = 16'd50;
  localparam logic [6:0]  MAX_RESET    = 7'd100;
  localparam logic [6:0]  LOW_RESET    = 7'd70;

  // volume saturation limit, mL Q8
  localparam logic [23:0] VOL_MAX = 24'hFFFFFF;

  typedef enum logic [2:0] {
    CMD_PULSE = 3'd0,
    CMD_TICK  = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_PUMP  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FILL = 2'd1,
    MODE_PUMP = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_READY,
    ST_DECODE,
    ST_VOL,
    ST_RATE,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    REG_CAL    = 2'd0,
    REG_OFFSET = 2'd1,
    REG_MAX    = 2'd2,
    REG_LOW    = 2'd3
  } reg_idx_t;

  // live configuration, percentages already turned into compare values
  typedef struct packed {
    logic [7:0]  cal;
    logic [15:0] offset;
    logic [7:0]  duty_max;
    logic [7:0]  duty_low;
  } cfg_t;

  // pct*255/100 by reciprocal multiply (655/65536 runs low by at most one),
  // then one compare and subtract to fix up
  function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
    logic [14:0] prod;
    logic [24:0] est;
    logic [7:0]  q;
    logic [14:0] rem;
    prod = 15'(pct) * 15'(PWM_TOP);
    est  = 25'(prod) * 25'd655;
    q    = est[23:16];
    rem  = prod - 15'(q) * 15'(PCT_FULL);
    if (pct > 7'(PCT_FULL)) begin
      return 8'(PWM_TOP);
    end
    if (rem >= 15'(PCT_FULL)) begin
      return q + 8'd1;
    end
    return q;
  endfunction

endpackage

// File: hw/rtl/fmfc_div.sv
// ----------------------------------------------------------------------------
// fmfc_div: bit-serial restoring divider
// One quotient bit per cycle; dividend shifts out as quotient shifts in.
// ----------------------------------------------------------------------------
module fmfc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fmfc_pkg::DIV_BITS-1:0] dividend,
  input  logic [7:0]                    divisor,
  output logic                          done,
  output logic [fmfc_pkg::DIV_BITS-1:0] quotient
);

  logic [fmfc_pkg::DIV_BITS-1:0] quo;
  logic [7:0]  rem;
  logic [7:0]  dsr;
  logic [fmfc_pkg::CNT_W-1:0] count;
  logic        busy;
  logic [8:0]  trial;
  logic        fits;

  // one restoring step
  assign trial = {rem, quo[fmfc_pkg::DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= fmfc_pkg::CNT_W'(fmfc_pkg::DIV_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == fmfc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[fmfc_pkg::DIV_BITS-2:0], fits};
      rem <= fits ? 8'(trial - {1'b0, dsr}) : trial[7:0];
    end
  end

  assign quotient = quo;

endmodule

// File: hw/rtl/fmfc_cfg.sv
// ----------------------------------------------------------------------------
// fmfc_cfg: configuration registers
// Holds calibration and offset; power percentages are stored as PWM compares.
// ----------------------------------------------------------------------------
module fmfc_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  output fmfc_pkg::cfg_t cfg
);

  // register writes, percent converted on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal      <= fmfc_pkg::CAL_RESET;
      cfg.offset   <= fmfc_pkg::OFFSET_RESET;
      cfg.duty_max <= fmfc_pkg::pct_to_duty(fmfc_pkg::MAX_RESET);
      cfg.duty_low <= fmfc_pkg::pct_to_duty(fmfc_pkg::LOW_RESET);
    end else if (cfg_we) begin
      unique case (fmfc_pkg::reg_idx_t'(cfg_index))
        fmfc_pkg::REG_CAL:    cfg.cal      <= cfg_wdata[7:0];
        fmfc_pkg::REG_OFFSET: cfg.offset   <= cfg_wdata;
        fmfc_pkg::REG_MAX:    cfg.duty_max <= fmfc_pkg::pct_to_duty(cfg_wdata[6:0]);
        fmfc_pkg::REG_LOW:    cfg.duty_low <= fmfc_pkg::pct_to_duty(cfg_wdata[6:0]);
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/flow_metered_fill_controller.sv
// ----------------------------------------------------------------------------
// flow_metered_fill_controller: liquid dosing controller
// Counts meter pulses, derives flow and volume on ticks, drives pump duty.
//
//   channel  dir  payload
//   s_*      in   command, target_ml
//   m_*      out  duty, mode, shown_volume_ml, flow_rate, fill_done
//   cfg_*    in   register writes (calibration, offset, max/low power)
//
// Pulse, start, stop and idle ticks go from READY through DECODE and EMIT back
// to READY. A running tick adds one pass of the serial divider for the volume
// step (VOL, then FINISH); the tick that updates flow, with a nonzero
// calibration, adds a second pass (RATE). Reset is synchronous and needs no
// sweep. A stalled result holds in the output register; the next item is not
// taken until it has been loaded there.
// ----------------------------------------------------------------------------
module flow_metered_fill_controller (
  input  logic        clk,
  input  logic        rst,
  // command [2:0], target_ml [18:3], zero pad [23:19]
  input  logic [23:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // duty [7:0], mode [9:8], shown_volume_ml [25:10], flow_rate [41:26],
  // fill_done [42], zero pad [47:43]
  output logic [47:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  fmfc_pkg::state_t state, state_next;
  fmfc_pkg::cfg_t   cfg;
  fmfc_pkg::mode_t  run_mode;
  fmfc_pkg::cmd_t   cmd_r;

  logic [15:0] tgt_r;
  logic [15:0] pulse_count;
  logic [2:0]  tick_phase;
  logic [15:0] flow_q8;
  logic [23:0] volume_q8;
  logic [15:0] target_volume;
  logic        done_r;

  logic        div_start;
  logic [fmfc_pkg::DIV_BITS-1:0] div_dividend;
  logic [7:0]  div_divisor;
  logic        div_done;
  logic [fmfc_pkg::DIV_BITS-1:0] div_quot;

  logic [2:0]  phase_inc;
  logic        phase_wrap;
  logic [18:0] flow_x5;
  logic [fmfc_pkg::DIV_BITS-1:0] pulse_scaled;
  logic [24:0] vol_sum;
  logic [7:0]  out_duty;
  logic [15:0] out_shown;
  logic        out_load;

  fmfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fmfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // tick arithmetic operands
  assign phase_inc    = tick_phase + 3'd1;
  assign phase_wrap   = phase_inc >= 3'(fmfc_pkg::TICKS_PER_RATE);
  assign flow_x5      = 19'({flow_q8, 2'b00}) + 19'(flow_q8);
  assign pulse_scaled = fmfc_pkg::DIV_BITS'({pulse_count, 13'b0})
                      + fmfc_pkg::DIV_BITS'({pulse_count, 11'b0});
  assign vol_sum      = 25'(volume_q8) + 25'(div_quot[15:0]);
  assign out_load     = !m_tvalid || m_tready;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmfc_pkg::ST_READY;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider launch
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      fmfc_pkg::ST_READY: begin
        if (s_tvalid) state_next = fmfc_pkg::ST_DECODE;
      end
      fmfc_pkg::ST_DECODE: begin
        if (cmd_r == fmfc_pkg::CMD_TICK && run_mode != fmfc_pkg::MODE_IDLE) begin
          div_start    = 1'b1;
          div_dividend = fmfc_pkg::DIV_BITS'(flow_x5);
          div_divisor  = 8'd6;
          state_next   = fmfc_pkg::ST_VOL;
        end else begin
          state_next = fmfc_pkg::ST_EMIT;
        end
      end
      fmfc_pkg::ST_VOL: begin
        if (div_done) begin
          if (phase_wrap && cfg.cal != 8'd0) begin
            div_start    = 1'b1;
            div_dividend = pulse_scaled;
            div_divisor  = cfg.cal;
            state_next   = fmfc_pkg::ST_RATE;
          end else begin
            state_next = fmfc_pkg::ST_FINISH;
          end
        end
      end
      fmfc_pkg::ST_RATE: begin
        if (div_done) state_next = fmfc_pkg::ST_FINISH;
      end
      fmfc_pkg::ST_FINISH: begin
        state_next = fmfc_pkg::ST_EMIT;
      end
      fmfc_pkg::ST_EMIT: begin
        if (out_load) state_next = fmfc_pkg::ST_READY;
      end
      default: state_next = fmfc_pkg::ST_READY;
    endcase
  end

  assign s_tready = state == fmfc_pkg::ST_READY;

  // result fields from the state left by this item
  always_comb begin
    out_duty  = '0;
    out_shown = volume_q8[23:8];
    unique case (run_mode)
      fmfc_pkg::MODE_FILL:
        out_duty = (volume_q8[23:8] < cfg.offset) ? cfg.duty_low : cfg.duty_max;
      fmfc_pkg::MODE_PUMP:
        out_duty = cfg.duty_max;
      default: out_duty = '0;
    endcase
    if ((run_mode == fmfc_pkg::MODE_FILL || done_r) && out_shown > target_volume) begin
      out_shown = target_volume;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (state == fmfc_pkg::ST_READY && s_tvalid) begin
      cmd_r <= fmfc_pkg::cmd_t'(s_tdata[2:0]);
      tgt_r <= s_tdata[18:3];
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == fmfc_pkg::ST_EMIT && out_load) begin
      m_tdata <= {5'b0, done_r, flow_q8, out_shown, run_mode, out_duty};
    end
  end

  // result valid: set on load, cleared once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == fmfc_pkg::ST_EMIT && out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= fmfc_pkg::MODE_IDLE;
      pulse_count   <= '0;
      tick_phase    <= '0;
      flow_q8       <= '0;
      volume_q8     <= '0;
      target_volume <= '0;
      done_r        <= 1'b0;
    end else begin
      unique case (state)
        fmfc_pkg::ST_READY: begin
          if (s_tvalid) done_r <= 1'b0;
        end
        fmfc_pkg::ST_DECODE: begin
          case (cmd_r) inside
            fmfc_pkg::CMD_PULSE: begin
              if (pulse_count != 16'hFFFF) pulse_count <= pulse_count + 16'd1;
            end
            fmfc_pkg::CMD_FILL, fmfc_pkg::CMD_PUMP: begin
              if (run_mode == fmfc_pkg::MODE_IDLE) begin
                run_mode      <= (cmd_r == fmfc_pkg::CMD_FILL) ? fmfc_pkg::MODE_FILL
                                                               : fmfc_pkg::MODE_PUMP;
                target_volume <= (cmd_r == fmfc_pkg::CMD_FILL) ? tgt_r : 16'd0;
                volume_q8     <= '0;
                flow_q8       <= '0;
                pulse_count   <= '0;
                tick_phase    <= '0;
              end
            end
            fmfc_pkg::CMD_STOP: begin
              run_mode      <= fmfc_pkg::MODE_IDLE;
              target_volume <= '0;
            end
            default: ;
          endcase
        end
        fmfc_pkg::ST_VOL: begin
          if (div_done) begin
            volume_q8  <= vol_sum[24] ? fmfc_pkg::VOL_MAX : vol_sum[23:0];
            tick_phase <= phase_wrap ? 3'd0 : phase_inc;
            // zero calibration: any pulse pins the flow at full scale
            if (phase_wrap && cfg.cal == 8'd0) begin
              flow_q8     <= (pulse_count != 16'd0) ? 16'hFFFF : 16'd0;
              pulse_count <= '0;
            end
          end
        end
        fmfc_pkg::ST_RATE: begin
          if (div_done) begin
            flow_q8     <= (div_quot[fmfc_pkg::DIV_BITS-1:16] != '0) ? 16'hFFFF
                                                                     : div_quot[15:0];
            pulse_count <= '0;
          end
        end
        fmfc_pkg::ST_FINISH: begin
          // target reached: end the fill, target kept one beat for the clamp
          if (run_mode == fmfc_pkg::MODE_FILL && volume_q8[23:8] >= target_volume) begin
            run_mode <= fmfc_pkg::MODE_IDLE;
            done_r   <= 1'b1;
          end
        end
        fmfc_pkg::ST_EMIT: begin
          if (out_load && done_r) target_volume <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a finished fill always reports idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[42] |-> m_tdata[9:8] == fmfc_pkg::MODE_IDLE)
    else $error("fill_done with a running mode");

  // no drive while idle
  a_idle_duty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9:8] == fmfc_pkg::MODE_IDLE |-> m_tdata[7:0] == 8'd0)
    else $error("nonzero duty while idle");

  // tick phase never reaches the rate interval
  a_phase: assert property (@(posedge clk) disable iff (rst)
    tick_phase < 3'(fmfc_pkg::TICKS_PER_RATE))
    else $error("tick phase out of range");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");
`endif

endmodule

// File: bench/tb_flow_metered_fill_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_metered_fill_controller: self-checking bench for the fill controller
// Drives command beats with bursty pacing, stalls the result side on shifting
// patterns and checks every result beat, field by field, against a cycle-free
// model of the controller's pulse, tick, fill and pump behavior.
// ----------------------------------------------------------------------------

// result beat, declared top field first so duty lands in the low bits
typedef struct packed {
  logic [4:0]  pad;
  logic        fill_done;
  logic [15:0] flow_rate;
  logic [15:0] shown_ml;
  logic [1:0]  mode;
  logic [7:0]  duty;
} fill_status_t;

typedef enum {
  STALL_NONE,
  STALL_SPARSE,
  STALL_THIRDS,
  STALL_MASK
} stall_kind_t;

class fill_status_board;
  // live configuration
  logic [7:0]      cal_tenths;
  logic [15:0]     offset_ml;
  logic [6:0]      max_pct;
  logic [6:0]      low_pct;
  // controller state
  fmfc_pkg::mode_t run_mode;
  logic [15:0]     pulses;
  logic [2:0]      tick_phase;
  logic [15:0]     flow_q8;
  logic [23:0]     volume_q8;
  logic [15:0]     target_ml;
  // results owed by the controller, oldest first
  fill_status_t    status_due_q[$];
  int unsigned     mismatches;
  int unsigned     checked;

  function new();
    cal_tenths = fmfc_pkg::CAL_RESET;
    offset_ml  = fmfc_pkg::OFFSET_RESET;
    max_pct    = fmfc_pkg::MAX_RESET;
    low_pct    = fmfc_pkg::LOW_RESET;
    run_mode   = fmfc_pkg::MODE_IDLE;
    pulses     = '0;
    tick_phase = '0;
    flow_q8    = '0;
    volume_q8  = '0;
    target_ml  = '0;
    mismatches = 0;
    checked    = 0;
  endfunction

  function void write_reg(fmfc_pkg::reg_idx_t idx, logic [15:0] val);
    case (idx)
      fmfc_pkg::REG_CAL:    cal_tenths = val[7:0];
      fmfc_pkg::REG_OFFSET: offset_ml  = val;
      fmfc_pkg::REG_MAX:    max_pct    = val[6:0];
      fmfc_pkg::REG_LOW:    low_pct    = val[6:0];
      default: ;
    endcase
  endfunction

  function logic [7:0] pct_duty(logic [6:0] pct);
    int unsigned p;
    p = pct;
    if (p > fmfc_pkg::PCT_FULL) return 8'(fmfc_pkg::PWM_TOP);
    return 8'((p * fmfc_pkg::PWM_TOP) / fmfc_pkg::PCT_FULL);
  endfunction

  function void start_run(fmfc_pkg::mode_t m, logic [15:0] tgt);
    run_mode   = m;
    target_ml  = tgt;
    volume_q8  = '0;
    flow_q8    = '0;
    pulses     = '0;
    tick_phase = '0;
  endfunction

  // advance the model by one accepted command and queue the status it owes
  function void note_command(logic [2:0] cmd, logic [15:0] tgt);
    fill_status_t st;
    int unsigned  sum;
    int unsigned  pc;
    int unsigned  f;
    logic         done;
    logic         clamp;
    logic [15:0]  clamp_ml;
    logic [15:0]  shown;
    st       = '0;
    done     = 1'b0;
    clamp    = 1'b0;
    clamp_ml = '0;
    case (cmd)
      fmfc_pkg::CMD_PULSE: begin
        if (pulses != 16'hFFFF) pulses = pulses + 16'd1;
      end
      fmfc_pkg::CMD_TICK: begin
        if (run_mode != fmfc_pkg::MODE_IDLE) begin
          // volume step first, from the flow of the previous window
          f   = flow_q8;
          sum = volume_q8 + (f * 5) / 6;
          volume_q8  = (sum > fmfc_pkg::VOL_MAX) ? fmfc_pkg::VOL_MAX : sum[23:0];
          tick_phase = tick_phase + 3'd1;
          if (tick_phase >= fmfc_pkg::TICKS_PER_RATE) begin
            tick_phase = '0;
            pc = pulses;
            if (cal_tenths == 8'd0) begin
              f = (pc != 0) ? 32'hFFFF : 32'd0;
            end else begin
              f = (pc * 10240) / cal_tenths;
            end
            flow_q8 = (f > 32'hFFFF) ? 16'hFFFF : f[15:0];
            pulses  = '0;
          end
          if (run_mode == fmfc_pkg::MODE_FILL && volume_q8 >= {target_ml, 8'h00}) begin
            clamp     = 1'b1;
            clamp_ml  = target_ml;
            run_mode  = fmfc_pkg::MODE_IDLE;
            target_ml = '0;
            done      = 1'b1;
          end
        end
      end
      fmfc_pkg::CMD_FILL: begin
        if (run_mode == fmfc_pkg::MODE_IDLE) start_run(fmfc_pkg::MODE_FILL, tgt);
      end
      fmfc_pkg::CMD_PUMP: begin
        if (run_mode == fmfc_pkg::MODE_IDLE) start_run(fmfc_pkg::MODE_PUMP, 16'd0);
      end
      fmfc_pkg::CMD_STOP: begin
        run_mode  = fmfc_pkg::MODE_IDLE;
        target_ml = '0;
      end
      default: ;
    endcase

    // power level and displayed volume after the command
    if (run_mode == fmfc_pkg::MODE_FILL) begin
      clamp    = 1'b1;
      clamp_ml = target_ml;
      st.duty  = (volume_q8 < {offset_ml, 8'h00}) ? pct_duty(low_pct) : pct_duty(max_pct);
    end else if (run_mode == fmfc_pkg::MODE_PUMP) begin
      st.duty = pct_duty(max_pct);
    end
    shown = volume_q8[23:8];
    if (clamp && shown > clamp_ml) shown = clamp_ml;

    st.mode      = run_mode;
    st.shown_ml  = shown;
    st.flow_rate = flow_q8;
    st.fill_done = done;
    status_due_q.push_back(st);
  endfunction

  task flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH result %0d: %s", checked, msg);
  endtask

  task check_status(logic [47:0] beat);
    fill_status_t got;
    fill_status_t want;
    got = fill_status_t'(beat);
    if (status_due_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result beat %h", beat));
      return;
    end
    want = status_due_q.pop_front();
    if (got.duty != want.duty)
      flag_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
    if (got.mode != want.mode)
      flag_mismatch($sformatf("mode %0d, want %0d", got.mode, want.mode));
    if (got.shown_ml != want.shown_ml)
      flag_mismatch($sformatf("shown volume %0d, want %0d", got.shown_ml, want.shown_ml));
    if (got.flow_rate != want.flow_rate)
      flag_mismatch($sformatf("flow %0d, want %0d", got.flow_rate, want.flow_rate));
    if (got.fill_done != want.fill_done)
      flag_mismatch($sformatf("fill_done %0d, want %0d", got.fill_done, want.fill_done));
    checked++;
  endtask
endclass

module tb_flow_metered_fill_controller;

  logic        clk;
  logic        rst       = 1'b1;
  // command [2:0], target_ml [18:3], zero pad [23:19]
  logic [23:0] s_tdata   = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  // duty [7:0], mode [9:8], shown_volume_ml [25:10], flow_rate [41:26],
  // fill_done [42], zero pad [47:43]
  logic [47:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  fill_status_board board;

  // sender pacing
  bit          pace_on    = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_len    = 0;

  // receiver stall pattern
  stall_kind_t stall_kind = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_pos  = 0;
  logic [7:0]  stall_mask = 8'hFF;

  flow_metered_fill_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_flow_metered_fill_controller failed");
    $finish;
  end

  // result side: check accepted beats, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_status(m_tdata);
    if (stall_left == 0) begin
      stall_kind = stall_kind_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
      stall_mask = 8'($urandom) | 8'h01;
      stall_pos  = 0;
    end else begin
      stall_left--;
    end
    case (stall_kind)
      STALL_NONE:   m_tready <= 1'b1;
      STALL_SPARSE: m_tready <= ($urandom_range(0, 3) != 0);
      STALL_THIRDS: m_tready <= (stall_pos % 3 == 0);
      default:      m_tready <= stall_mask[stall_pos % 8];
    endcase
    stall_pos++;
  end

  // one command beat; holds valid until taken, then maybe idles a while
  task send_beat(input logic [2:0] cmd, input logic [15:0] tgt);
    s_tdata  <= {5'b0, tgt, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_command(cmd, tgt);
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap_len    = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold off the sender until every owed result has come back
  task drain;
    s_tvalid <= 1'b0;
    while (board.status_due_q.size() != 0) @(posedge clk);
  endtask

  // all four registers on back-to-back edges; spare high bits are junk
  task set_config(input logic [7:0] cal, input logic [15:0] off,
                  input logic [6:0] maxp, input logic [6:0] lowp);
    logic [15:0] vals [4];
    vals[0] = {8'($urandom), cal};
    vals[1] = off;
    vals[2] = {9'($urandom), maxp};
    vals[3] = {9'($urandom), lowp};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.write_reg(fmfc_pkg::reg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly complete fill or pump runs with random pulse density, some noise
  task run_random(input int unsigned n);
    int unsigned counted;
    int unsigned steps;
    int unsigned pulse_rate;
    int unsigned cap;
    logic [15:0] tgt;
    counted = 0;
    pace_on = ($urandom_range(0, 3) != 0);
    while (counted < n) begin
      if ($urandom_range(0, 9) < 7) begin
        if (board.run_mode != fmfc_pkg::MODE_IDLE) begin
          send_beat(fmfc_pkg::CMD_STOP, 16'($urandom));
          counted++;
        end
        pulse_rate = $urandom_range(1, 10);
        if ($urandom_range(0, 3) == 0) begin
          send_beat(fmfc_pkg::CMD_PUMP, 16'($urandom));
          cap = $urandom_range(10, 50);
        end else begin
          tgt = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 400))
                                            : 16'($urandom_range(0, 40));
          send_beat(fmfc_pkg::CMD_FILL, tgt);
          cap = 70;
        end
        counted++;
        steps = 0;
        while (board.run_mode != fmfc_pkg::MODE_IDLE && steps < cap) begin
          repeat ($urandom_range(0, pulse_rate)) begin
            send_beat(fmfc_pkg::CMD_PULSE, 16'($urandom));
            steps++;
          end
          // now and then a start, stop or bad code lands mid-run
          if ($urandom_range(0, 19) == 0) send_beat(3'($urandom_range(2, 7)), 16'($urandom));
          else send_beat(fmfc_pkg::CMD_TICK, 16'($urandom));
          steps++;
        end
        counted += steps;
        if (board.run_mode != fmfc_pkg::MODE_IDLE) begin
          send_beat(fmfc_pkg::CMD_STOP, 16'($urandom));
          counted++;
        end
      end else begin
        send_beat(3'($urandom_range(0, 7)), 16'($urandom));
        counted++;
      end
    end
    drain();
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle behavior, bad codes, zero target, starts while running
    pace_on = 1'b1;
    send_beat(fmfc_pkg::CMD_TICK, 16'h0000);
    send_beat(fmfc_pkg::CMD_PULSE, 16'hFFFF);
    send_beat(fmfc_pkg::CMD_PULSE, 16'h0000);
    send_beat(fmfc_pkg::CMD_STOP, 16'hFFFF);
    send_beat(3'd5, 16'hFFFF);
    send_beat(3'd6, 16'h0000);
    send_beat(3'd7, 16'hFFFF);
    send_beat(fmfc_pkg::CMD_FILL, 16'h0000);
    send_beat(fmfc_pkg::CMD_TICK, 16'h0000);
    send_beat(fmfc_pkg::CMD_PUMP, 16'hFFFF);
    send_beat(fmfc_pkg::CMD_FILL, 16'hFFFF);
    send_beat(fmfc_pkg::CMD_PUMP, 16'h0000);
    repeat (3) send_beat(fmfc_pkg::CMD_PULSE, 16'h0000);
    repeat (6) send_beat(fmfc_pkg::CMD_TICK, 16'h0000);
    send_beat(fmfc_pkg::CMD_STOP, 16'h0000);
    send_beat(fmfc_pkg::CMD_FILL, 16'hFFFF);
    send_beat(fmfc_pkg::CMD_TICK, 16'h0000);
    send_beat(fmfc_pkg::CMD_STOP, 16'h0000);
    drain();

    // extreme settings, then a run of random ones
    set_config(8'd1, 16'd0, 7'd0, 7'd100);
    run_random(40);
    set_config(8'd255, 16'hFFFF, 7'd127, 7'd101);
    run_random(40);
    set_config(8'd0, 16'd3, 7'd100, 7'd0);
    run_random(40);
    repeat (3) begin
      set_config(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(20, 120)),
                 16'($urandom_range(0, 40)),
                 ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100)),
                 ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100)));
      run_random(40);
    end

    // saturated flow at the lowest calibration
    set_config(8'd1, 16'd0, 7'd100, 7'd100);
    pace_on = 1'b0;
    send_beat(fmfc_pkg::CMD_PUMP, 16'h0000);
    repeat (4) begin
      repeat (7) send_beat(fmfc_pkg::CMD_PULSE, 16'($urandom));
      repeat (5) send_beat(fmfc_pkg::CMD_TICK, 16'($urandom));
    end
    send_beat(fmfc_pkg::CMD_STOP, 16'h0000);
    drain();

    repeat (80) @(posedge clk);
    if (board.mismatches == 0 && board.status_due_q.size() == 0) begin
      $display("tb_flow_metered_fill_controller passed");
    end else begin
      $display("tb_flow_metered_fill_controller failed");
    end
    $finish;
  end

endmodule
